@@ src/mtb_pkg.sv @@
package mtb_pkg;

  localparam int FRAC_BITS = 16;

  // Density Q3.F (integer part 0..7), its squared sum, root and quotient widths.
  localparam int DW  = FRAC_BITS + 3;
  localparam int SW  = 2 * DW + 2;
  localparam int MW  = SW / 2;
  localparam int RW  = MW + 1;
  localparam int QW  = FRAC_BITS + 1;
  localparam int NW  = FRAC_BITS + 4;
  localparam int AW  = FRAC_BITS + 3;
  localparam int PW  = AW + 30;
  localparam int HW  = PW + 7;
  localparam int HMW = HW - FRAC_BITS - 30;

  localparam logic [SW-1:0] THRESH =
    SW'((64'd1 << (2 * FRAC_BITS)) / 64'd100000000);

  localparam logic [29:0] INV_SQRT2 = 30'd759250125;
  localparam logic [29:0] INV_SQRT6 = 30'd438353264;
  localparam logic [31:0] COL_SCALE = 32'd3796250625;
  localparam logic [31:0] ROW_SCALE = 32'd3787372202;
  localparam logic [8:0]  COL_BASE  = 9'd250;
  localparam logic [8:0]  ROW_BASE  = 9'd288;
  localparam logic signed [41:0] COL_OFF = 42'sd250 <<< 30;
  localparam logic signed [41:0] ROW_OFF = 42'sd288 <<< 30;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pix_t;

  typedef struct packed {
    logic signed [7:0] coord_a_hundredths;
    logic signed [7:0] coord_b_hundredths;
    logic [8:0]        bin_column;
    logic [8:0]        bin_row;
    logic              achromatic;
  } res_t;

  typedef struct packed {
    logic              valid;
    logic              achro;
    logic [2:0][DW-1:0] d;
    logic [SW-1:0]     sumsq;
  } sq_t;

  typedef struct packed {
    logic              valid;
    logic              achro;
    logic [2:0][DW-1:0] d;
    logic [MW-1:0]     mag;
  } mag_t;

  typedef struct packed {
    logic              valid;
    logic              achro;
    logic [2:0][QW-1:0] u;
  } unit_t;

  typedef logic [DW-1:0] dens_tab_t [256];

  // Optical density log2(255/c) per byte value, built at elaboration.
  function automatic dens_tab_t dens_tab_gen();
    dens_tab_t tab;
    longint unsigned c, k, m, frac, num, den, rr;
    for (int n = 0; n < 256; n++) begin
      c = (n == 0) ? 64'd1 : 64'(n);
      k = 0;
      while (k < 7 && ((c << (k + 1)) <= 64'd255)) k++;
      // Long division of 255 * 2^30 by c * 2^k, one quotient bit per step.
      num = 64'd255 << 30;
      den = c << k;
      rr  = 0;
      m   = 0;
      for (int j = 39; j >= 0; j--) begin
        rr = (rr << 1) | ((num >> j) & 64'd1);
        m  = m << 1;
        if (rr >= den) begin
          rr = rr - den;
          m  = m | 64'd1;
        end
      end
      frac = 0;
      for (int i = 0; i < FRAC_BITS; i++) begin
        m = (m * m) >> 30;
        frac = frac << 1;
        if (m >= 64'd2147483648) begin
          frac = frac | 64'd1;
          m = m >> 1;
        end
      end
      tab[n] = DW'((k << FRAC_BITS) | frac);
    end
    return tab;
  endfunction

  localparam dens_tab_t DENS_TAB = dens_tab_gen();

endpackage

@@ src/rgb_to_maxwell_triangle_bin.sv @@
// Pipeline from pixel beat to result beat: front end, bit-per-stage square root (MW stages),
// divider (QW stages) and projection.
// Throughput: one pixel per clock; a stalled result beat freezes the whole pipeline.
// Reset: rst, synchronous, active high, clears all stage valid bits; no data is cleared.
module rgb_to_maxwell_triangle_bin import mtb_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic pix_valid,
  output logic pix_ready,
  input  pix_t pix,
  output logic res_valid,
  input  logic res_ready,
  output res_t res
);

  logic  en;
  sq_t   sq;
  mag_t  mg;
  unit_t un;

  assign en        = !res_valid || res_ready;
  assign pix_ready = en;

  mtb_front u_front (.clk, .rst, .en, .pix_valid, .pix, .sq);
  mtb_sqrt  u_sqrt  (.clk, .rst, .en, .sq, .mg);
  mtb_div   u_div   (.clk, .rst, .en, .mg, .un);
  mtb_proj  u_proj  (.clk, .rst, .en, .un, .res_valid, .res);

  a_achro_fixed: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.achromatic |->
      res.coord_a_hundredths == 8'sd0 && res.coord_b_hundredths == 8'sd0 &&
      res.bin_column == COL_BASE && res.bin_row == ROW_BASE)
    else $error("achromatic result not centered");

  a_col_side: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res.coord_a_hundredths[7] |-> res.bin_column >= COL_BASE)
    else $error("bin column on wrong side of center");

  a_coord_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res.coord_a_hundredths <= 8'sd71 && res.coord_a_hundredths >= -8'sd71)
    else $error("coordinate a outside unit-vector range");

endmodule

@@ src/mtb_front.sv @@
module mtb_front import mtb_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic pix_valid,
  input  pix_t pix,
  output sq_t  sq
);

  logic v1, v2, v3;
  logic [2:0][DW-1:0]   d1, d2, d3;
  logic [2:0][2*DW-1:0] sq2;
  logic [SW-1:0]        sum_c, sum3;
  logic                 achro3;

  assign sum_c = SW'(sq2[0]) + SW'(sq2[1]) + SW'(sq2[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v1 <= pix_valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d1[0] <= DENS_TAB[pix.red];
      d1[1] <= DENS_TAB[pix.green];
      d1[2] <= DENS_TAB[pix.blue];
      for (int i = 0; i < 3; i++) begin
        sq2[i] <= (2*DW)'(d1[i]) * (2*DW)'(d1[i]);
      end
      d2     <= d1;
      d3     <= d2;
      sum3   <= sum_c;
      achro3 <= (sum_c <= THRESH);
    end
  end

  assign sq = '{valid: v3, achro: achro3, d: d3, sumsq: sum3};

endmodule

@@ src/mtb_sqrt.sv @@
module mtb_sqrt import mtb_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  sq_t  sq,
  output mag_t mg
);

  logic               vld  [MW];
  logic               ach  [MW];
  logic [2:0][DW-1:0] dd   [MW];
  logic [SW-1:0]      rad  [MW];
  logic [RW-1:0]      rem  [MW];
  logic [MW-1:0]      root [MW];

  // One root bit per stage, two radicand bits consumed per stage.
  for (genvar s = 0; s < MW; s++) begin : g_stage
    logic               vi, ai;
    logic [2:0][DW-1:0] di;
    logic [SW-1:0]      radi;
    logic [RW-1:0]      remi;
    logic [MW-1:0]      rooti;
    logic [RW+1:0]      rem2, trial;
    logic               ge;

    if (s == 0) begin : g_first
      assign vi    = sq.valid;
      assign ai    = sq.achro;
      assign di    = sq.d;
      assign radi  = sq.sumsq;
      assign remi  = '0;
      assign rooti = '0;
    end else begin : g_next
      assign vi    = vld[s-1];
      assign ai    = ach[s-1];
      assign di    = dd[s-1];
      assign radi  = rad[s-1];
      assign remi  = rem[s-1];
      assign rooti = root[s-1];
    end

    assign rem2  = {remi, radi[SW-1 -: 2]};
    assign trial = {1'b0, rooti, 2'b01};
    assign ge    = (rem2 >= trial);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s] <= 1'b0;
      end else if (en) begin
        vld[s] <= vi;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        ach[s]  <= ai;
        dd[s]   <= di;
        rad[s]  <= radi << 2;
        rem[s]  <= ge ? RW'(rem2 - trial) : RW'(rem2);
        root[s] <= {rooti[MW-2:0], ge};
      end
    end
  end

  assign mg = '{valid: vld[MW-1], achro: ach[MW-1], d: dd[MW-1],
                mag: (root[MW-1] == '0) ? MW'(1) : root[MW-1]};

endmodule

@@ src/mtb_div.sv @@
module mtb_div import mtb_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  en,
  input  mag_t  mg,
  output unit_t un
);

  logic               vld [QW];
  logic               ach [QW];
  logic [MW-1:0]      dv  [QW];
  logic [2:0][MW-1:0] rem [QW];
  logic [2:0][QW-1:0] q   [QW];

  // Restoring division of d<<F by the magnitude, one quotient bit per stage.
  // Since d never exceeds the magnitude, the quotient fits in F+1 bits.
  for (genvar s = 0; s < QW; s++) begin : g_stage
    logic               vi, ai;
    logic [MW-1:0]      magi;
    logic [2:0][MW-1:0] remi;
    logic [2:0][QW-1:0] qi;
    logic [2:0]         nbit, ge;
    logic [2:0][MW:0]   rem2;
    logic [2:0][MW-1:0] rem_n;

    if (s == 0) begin : g_first
      assign vi   = mg.valid;
      assign ai   = mg.achro;
      assign magi = mg.mag;
      assign qi   = '0;
      for (genvar l = 0; l < 3; l++) begin : g_lane
        assign remi[l] = MW'(mg.d[l] >> 1);
        assign nbit[l] = mg.d[l][0];
      end
    end else begin : g_next
      assign vi   = vld[s-1];
      assign ai   = ach[s-1];
      assign magi = dv[s-1];
      assign qi   = q[s-1];
      assign remi = rem[s-1];
      assign nbit = '0;
    end

    always_comb begin
      for (int l = 0; l < 3; l++) begin
        rem2[l]  = {remi[l], nbit[l]};
        ge[l]    = (rem2[l] >= {1'b0, magi});
        rem_n[l] = ge[l] ? MW'(rem2[l] - {1'b0, magi}) : MW'(rem2[l]);
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s] <= 1'b0;
      end else if (en) begin
        vld[s] <= vi;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        ach[s] <= ai;
        dv[s]  <= magi;
        rem[s] <= rem_n;
        for (int l = 0; l < 3; l++) begin
          q[s][l] <= {qi[l][QW-2:0], ge[l]};
        end
      end
    end
  end

  // An achromatic pixel has an all-zero unit vector.
  assign un = '{valid: vld[QW-1], achro: ach[QW-1],
                u: ach[QW-1] ? '0 : q[QW-1]};

endmodule

@@ src/mtb_proj.sv @@
module mtb_proj import mtb_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  en,
  input  unit_t un,
  output logic  res_valid,
  output res_t  res
);

  logic v1, v2, v3, v4;
  logic a1, a2, a3, a4;

  logic signed [NW-1:0] ua, ub, uc, na, nb;
  logic                 sa1, sb1, sa2, sb2;
  logic [AW-1:0]        ma1, mb1;
  logic [PW-1:0]        pa2, pb2;
  logic [HW-1:0]        ta, tb;
  logic signed [7:0]    ha3, hb3, ha4, hb4, ha_c, hb_c;
  logic signed [40:0]   pc4, pr4;
  logic signed [41:0]   vcol, vrow;
  logic [8:0]           col_c, row_c;

  function automatic logic signed [7:0] hund_sat(input logic neg, input logic [HMW-1:0] m);
    logic signed [7:0] r;
    if (!neg) begin
      r = (m > HMW'(127)) ? 8'sd127 : 8'(m);
    end else begin
      r = (m >= HMW'(128)) ? -8'sd128 : -8'(m);
    end
    return r;
  endfunction

  function automatic logic [8:0] bin_sat(input logic signed [41:0] v);
    logic [8:0] r;
    if (v < 0) begin
      r = '0;
    end else if (v[41:30] > 12'd511) begin
      r = 9'd511;
    end else begin
      r = v[38:30];
    end
    return r;
  endfunction

  assign ua = NW'($signed({1'b0, un.u[0]}));
  assign ub = NW'($signed({1'b0, un.u[1]}));
  assign uc = NW'($signed({1'b0, un.u[2]}));
  assign na = ua - ub;
  assign nb = (uc <<< 1) - ua - ub;

  assign ta   = HW'(pa2) * HW'(7'd100);
  assign tb   = HW'(pb2) * HW'(7'd100);
  assign ha_c = hund_sat(sa2, ta[HW-1:FRAC_BITS+30]);
  assign hb_c = hund_sat(sb2, tb[HW-1:FRAC_BITS+30]);

  assign vcol  = COL_OFF + 42'(pc4);
  assign vrow  = ROW_OFF - 42'(pr4);
  assign col_c = bin_sat(vcol);
  assign row_c = bin_sat(vrow);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      res_valid <= 1'b0;
    end else if (en) begin
      v1        <= un.valid;
      v2        <= v1;
      v3        <= v2;
      v4        <= v3;
      res_valid <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a1  <= un.achro;
      sa1 <= na[NW-1];
      sb1 <= nb[NW-1];
      ma1 <= AW'(na[NW-1] ? -na : na);
      mb1 <= AW'(nb[NW-1] ? -nb : nb);

      a2  <= a1;
      sa2 <= sa1;
      sb2 <= sb1;
      pa2 <= PW'(ma1) * PW'(INV_SQRT2);
      pb2 <= PW'(mb1) * PW'(INV_SQRT6);

      a3  <= a2;
      ha3 <= ha_c;
      hb3 <= hb_c;

      a4  <= a3;
      ha4 <= ha3;
      hb4 <= hb3;
      pc4 <= 41'(ha3) * 41'($signed({1'b0, COL_SCALE}));
      pr4 <= 41'(hb3) * 41'($signed({1'b0, ROW_SCALE}));

      res.achromatic         <= a4;
      res.coord_a_hundredths <= ha4;
      res.coord_b_hundredths <= hb4;
      res.bin_column         <= col_c;
      res.bin_row            <= row_c;
    end
  end

endmodule
